@@ hdl/pbis_pkg.sv @@
// Package for the packed bit-field index store.
// Holds field widths, default sizes, status and operation codes and the width clamp.
// Used by pbis_div and the top level; it depends on nothing.
package pbis_pkg;

    localparam int KEY_W    = 17;
    localparam int SPB_W    = 16;
    localparam int VW_W     = 6;
    localparam int DATA_W   = 32;
    localparam int BP_W     = SPB_W + VW_W;
    localparam int WIN_BYTES = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam int BLOCK_BYTES_DEF = 4096;
    localparam int BLOCK_COUNT_DEF = 4;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_VALUE_WIDTH     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_PER_BLOCK = 1'd1;

    localparam logic [VW_W-1:0]  VW_RESET  = 6'd1;
    localparam logic [SPB_W-1:0] SPB_RESET = 16'd32768;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_WIDE  = 2'd2
    } t_status;

    function automatic logic [VW_W-1:0] eff_width(input logic [VW_W-1:0] vw);
        logic [VW_W-1:0] res;
        res = vw;
        if (vw == '0) begin
            res = VW_W'(1);
        end else if (vw > VW_W'(DATA_W)) begin
            res = VW_W'(DATA_W);
        end
        return res;
    endfunction

endpackage

@@ hdl/pbis_ram.sv @@
// Generic single-port RAM with a registered read port.
// Width and depth are parameters; it depends on nothing else.
module pbis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/pbis_div.sv @@
// Iterative restoring divider that splits a key into block and slot.
// One quotient bit per cycle through a shared subtractor; uses pbis_pkg.
module pbis_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pbis_pkg::KEY_W-1:0] i_dividend,
    input  logic [pbis_pkg::SPB_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [pbis_pkg::KEY_W-1:0] o_quot,
    output logic [pbis_pkg::SPB_W-1:0] o_rem
);
    import pbis_pkg::*;

    localparam int CNT_W = $clog2(KEY_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [KEY_W-1:0] r_quo;
    logic [SPB_W-1:0] r_rem;
    logic [SPB_W-1:0] r_dvs;
    logic [SPB_W:0]   rem_sh;
    logic [SPB_W+1:0] diff;

    assign rem_sh = {r_rem, r_quo[KEY_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(KEY_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[SPB_W+1]) begin
                r_rem <= diff[SPB_W-1:0];
                r_quo <= {r_quo[KEY_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[SPB_W-1:0];
                r_quo <= {r_quo[KEY_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

@@ hdl/packed_bitfield_index_store.sv @@
// Top level of the packed bit-field index store: sequencer, checks and byte memory.
// Instantiates pbis_div and pbis_ram; uses pbis_pkg.
//
// Usage. The input channel (i_in_valid / o_in_stall) carries one word of op, key and
// write value. The output channel (o_out_valid / i_out_stall) returns one word of read
// value and status for every input word, in order. The configuration channel
// (i_cfg_valid / o_cfg_ready) writes value_width (index 0) or slots_per_block (index 1)
// and is always ready; write it only while no word is in flight.
// After reset the memory of BLOCK_BYTES * BLOCK_COUNT bytes (16384 by default) is
// cleared one byte per cycle, with the input stalled.
// A word then passes through the key divider, whose one-bit-per-cycle subtractor
// takes most of its time, then the checks and the address arithmetic, the four
// single-port byte reads, the merge and the load of the output register. A put adds
// 4 byte writes after the merge. When slots_per_block is zero a word goes straight
// to the done state with a range status; a word rejected by the checks skips the
// address, read, merge and write steps. One word is in work at a time.
// The result is held in an output register: the next word is taken while it waits,
// but a stalled result holds the sequencer in its final state until it is taken.
module packed_bitfield_index_store #(
    parameter int BLOCK_BYTES = pbis_pkg::BLOCK_BYTES_DEF,
    parameter int BLOCK_COUNT = pbis_pkg::BLOCK_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_op,
    input  logic [pbis_pkg::KEY_W-1:0]     i_key,
    input  logic [pbis_pkg::DATA_W-1:0]    i_write_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [pbis_pkg::DATA_W-1:0]    o_read_value,
    output logic [1:0]                     o_status,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pbis_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pbis_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import pbis_pkg::*;

    localparam int MEM_BYTES = BLOCK_BYTES * BLOCK_COUNT;
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int OFF_W     = $clog2(BLOCK_BYTES);
    localparam int BLK_W     = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int OFFR_W    = BP_W - 3;
    localparam int CNT_W     = 3;

    localparam logic [OFFR_W-1:0] LAST_OFF   = OFFR_W'(BLOCK_BYTES - WIN_BYTES);
    localparam logic [BP_W:0]     BLOCK_BITS = (BP_W + 1)'(BLOCK_BYTES * 8);
    localparam logic [ADDR_W-1:0] CLR_LAST   = ADDR_W'(MEM_BYTES - 1);
    localparam logic [KEY_W-1:0]  BLK_LIMIT  = KEY_W'(BLOCK_COUNT);
    localparam logic [CNT_W-1:0]  RD_LAST    = CNT_W'(WIN_BYTES);
    localparam logic [CNT_W-1:0]  WR_LAST    = CNT_W'(WIN_BYTES - 1);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_DIV   = 9'b000000100,
        S_CHK   = 9'b000001000,
        S_ADDR  = 9'b000010000,
        S_RD    = 9'b000100000,
        S_MRG   = 9'b001000000,
        S_WR    = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [VW_W-1:0]    r_vw;
    logic [SPB_W-1:0]   r_spb;
    logic [CNT_W-1:0]   r_cnt;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_value;
    t_status            r_out_status;

    logic               r_op;
    logic [DATA_W-1:0]  r_wval;
    logic [VW_W-1:0]    r_width;
    logic [DATA_W-1:0]  r_mask;
    logic [BP_W-1:0]    r_bitpos;
    logic [BLK_W-1:0]   r_blk;
    logic [OFF_W-1:0]   r_off;
    logic [4:0]         r_sh;
    logic [ADDR_W-1:0]  r_addr;
    logic [DATA_W-1:0]  r_win;
    logic [DATA_W-1:0]  r_new;
    logic [DATA_W-1:0]  r_res_value;
    t_status            r_res_status;

    logic               in_accept;
    logic               out_free;
    logic               div_start;
    logic               div_done;
    logic [KEY_W-1:0]   div_quot;
    logic [SPB_W-1:0]   div_rem;
    logic [VW_W-1:0]    in_width;
    logic [BP_W:0]      bit_end;
    logic               range_err;
    logic               wide_err;
    logic [OFFR_W-1:0]  off_raw;
    logic [OFFR_W-1:0]  over;
    logic               clamp;
    logic [4:0]         sh_chk;
    logic [OFF_W-1:0]   off_chk;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [7:0]         ram_wdata;
    logic [7:0]         ram_rdata;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign div_start   = in_accept && (r_spb != '0);
    assign in_width    = eff_width(r_vw);
    assign o_cfg_ready = 1'b1;

    pbis_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_key),
        .i_divisor  (r_spb),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    pbis_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        bit_end   = {1'b0, r_bitpos} + (BP_W + 1)'(r_width);
        range_err = (div_quot >= BLK_LIMIT) || (bit_end > BLOCK_BITS);
        wide_err  = (r_op == OP_PUT) && ((r_wval & ~r_mask) != '0);
        off_raw   = r_bitpos[BP_W-1:3];
        over      = off_raw - LAST_OFF;
        clamp     = (off_raw > LAST_OFF);
        if (clamp) begin
            sh_chk  = {over[1:0], 3'b000} + {2'b00, r_bitpos[2:0]};
            off_chk = OFF_W'(LAST_OFF);
        end else begin
            sh_chk  = {2'b00, r_bitpos[2:0]};
            off_chk = OFF_W'(off_raw);
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_addr + ADDR_W'(r_cnt[1:0]);
        ram_wdata = r_new[7:0];
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr_addr;
                ram_wdata = '0;
            end
            S_WR: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == CLR_LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_accept) n_state = (r_spb == '0) ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (div_done) n_state = S_CHK;
            end
            S_CHK: begin
                n_state = (range_err || wide_err) ? S_DONE : S_ADDR;
            end
            S_ADDR: begin
                n_state = S_RD;
            end
            S_RD: begin
                if (r_cnt == RD_LAST) n_state = S_MRG;
            end
            S_MRG: begin
                n_state = (r_op == OP_PUT) ? S_WR : S_DONE;
            end
            S_WR: begin
                if (r_cnt == WR_LAST) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_vw        <= VW_RESET;
            r_spb       <= SPB_RESET;
            r_cnt       <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_VALUE_WIDTH) begin
                    r_vw <= i_cfg_data[VW_W-1:0];
                end else if (i_cfg_index == REG_SLOTS_PER_BLOCK) begin
                    r_spb <= i_cfg_data[SPB_W-1:0];
                end
            end
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            case (r_state)
                S_ADDR:  r_cnt <= '0;
                S_RD:    r_cnt <= r_cnt + CNT_W'(1);
                S_MRG:   r_cnt <= '0;
                S_WR:    r_cnt <= r_cnt + CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_op         <= i_op;
                    r_wval       <= i_write_value;
                    r_width      <= in_width;
                    r_mask       <= {DATA_W{1'b1}} >> (VW_W'(DATA_W) - in_width);
                    r_res_value  <= '0;
                    r_res_status <= (r_spb == '0) ? ST_RANGE : ST_OK;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    r_bitpos <= BP_W'(div_rem) * BP_W'(r_width);
                end
            end
            S_CHK: begin
                r_blk <= BLK_W'(div_quot);
                r_off <= off_chk;
                r_sh  <= sh_chk;
                if (range_err) begin
                    r_res_status <= ST_RANGE;
                end else if (wide_err) begin
                    r_res_status <= ST_WIDE;
                end
            end
            S_ADDR: begin
                r_addr <= ADDR_W'(32'(r_blk) * 32'(BLOCK_BYTES) + 32'(r_off));
            end
            S_RD: begin
                if (r_cnt != '0) begin
                    r_win <= {ram_rdata, r_win[DATA_W-1:8]};
                end
            end
            S_MRG: begin
                if (r_op == OP_GET) begin
                    r_res_value <= (r_win >> r_sh) & r_mask;
                end
                r_new <= (r_win & ~(r_mask << r_sh)) | (r_wval << r_sh);
            end
            S_WR: begin
                r_new <= r_new >> 8;
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_value  <= r_res_value;
                    r_out_status <= r_res_status;
                end
            end
            default: begin
                r_op <= r_op;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_status     = r_out_status;

    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_read_value == '0))
        else $error("error result carries a non-zero read value");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == S_CLEAR) || ((r_state == S_WR) && (r_op == OP_PUT))))
        else $error("memory written outside the clear pass or a put");

    a_div_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

endmodule
